FILE: sv/chunk_task_balancer_core_defines.svh
// Assertion macros for the bound checker.
`ifndef CHUNK_TASK_BALANCER_CORE_DEFINES_SVH
`define CHUNK_TASK_BALANCER_CORE_DEFINES_SVH

// Same-cycle implication, switched off while reset is held.
`define CTB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, switched off while reset is held.
`define CTB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: sv/ctb_pkg.sv
`default_nettype none

package ctb_pkg;

    // Field widths of the item and result channels
    localparam int FUNC_W   = 2;
    localparam int WORKER_W = 5;
    localparam int CHUNK_W  = 4;
    localparam int QC_W     = 10;
    localparam int TGT_W    = 4;
    localparam int RT_W     = 15;

    // Configuration port
    localparam int CFG_AW     = 2;
    localparam int CFG_DW     = 11;
    localparam int CFG_QCC_W  = 11;
    localparam int CFG_DBC_W  = 5;
    localparam int CFG_WC_W   = 6;

    localparam logic [CFG_AW-1:0] CFG_QUERY_CHUNKS = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_DB_CHUNKS    = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_WORKERS      = 2'd2;

    // Request codes
    localparam logic [FUNC_W-1:0] FUNC_SET_MAP = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_TAKE    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_PICK    = 2'd2;

    // Sequencer states
    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_EXEC = 5'b00010,
        ST_LOAD = 5'b00100,
        ST_SCAN = 5'b01000,
        ST_FIN  = 5'b10000
    } t_state;

endpackage

`default_nettype wire

FILE: sv/ctb_ratio_cmp.sv
`default_nettype none

// Exact ratio compare: rem/load > best_rem/best_load, by cross products.
module ctb_ratio_cmp #(
    parameter int REM_W = 11,
    parameter int LD_W  = 6
) (
    input  wire logic [REM_W-1:0] i_rem,
    input  wire logic [LD_W-1:0]  i_load,
    input  wire logic [REM_W-1:0] i_best_rem,
    input  wire logic [LD_W-1:0]  i_best_load,
    output logic                  o_greater
);

    logic [REM_W+LD_W-1:0] prod_cand;
    logic [REM_W+LD_W-1:0] prod_best;

    // Form both cross products and compare
    always_comb begin
        prod_cand = (REM_W+LD_W)'(i_rem) * (REM_W+LD_W)'(i_best_load);
        prod_best = (REM_W+LD_W)'(i_best_rem) * (REM_W+LD_W)'(i_load);
        o_greater = prod_cand > prod_best;
    end

endmodule

`default_nettype wire

FILE: sv/chunk_task_balancer_core.sv
// Task dispatcher over database chunks.
// Input channel: i_valid / o_stall carries one request item (i_func, i_worker,
// i_chunk). Output channel: o_valid / i_stall carries one result item per
// request. Configuration: i_cfg_we writes register i_cfg_addr with i_cfg_data;
// any write to a mapped register refills every chunk counter with the query chunk count.
// Requests: set a worker's loaded chunk, take the next task of a chunk, or
// pick a switch target. Every result carries the total of remaining tasks.
// Set and take requests pass from an execute step to the final step. For a
// pick request the sequencer walks the loading map one worker per cycle and
// then the chunks one per cycle through a single cross-product compare unit,
// stopping early at the first idle chunk with work.
// One request is in flight at a time: o_stall is high from acceptance until
// the result is loaded into the output register.
// When the receiver stalls, the result is held in the output register and the
// sequencer waits in its final step; no new item is accepted until it is loaded.
// Synchronous reset (i_rst_n low) sets every configuration register to 1, every chunk
// counter to 1, clears the loading map and empties the output register.
`default_nettype none

module chunk_task_balancer_core
    import ctb_pkg::*;
#(
    parameter int MAX_DB_CHUNKS    = 16,
    parameter int MAX_WORKERS      = 32,
    parameter int MAX_QUERY_CHUNKS = 1024
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // configuration
    input  wire logic                i_cfg_we,
    input  wire logic [CFG_AW-1:0]   i_cfg_addr,
    input  wire logic [CFG_DW-1:0]   i_cfg_data,
    // request items
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire logic [FUNC_W-1:0]   i_func,
    input  wire logic [WORKER_W-1:0] i_worker,
    input  wire logic [CHUNK_W-1:0]  i_chunk,
    // result items
    output logic                     o_valid,
    input  wire logic                i_stall,
    output logic                     o_task_valid,
    output logic [QC_W-1:0]          o_query_idx,
    output logic [CHUNK_W-1:0]       o_db_chunk,
    output logic [TGT_W-1:0]         o_switch_chunk,
    output logic [RT_W-1:0]          o_remaining_total
);

    localparam int QW  = $clog2(MAX_QUERY_CHUNKS + 1);
    localparam int DW  = $clog2(MAX_DB_CHUNKS + 1);
    localparam int WCW = $clog2(MAX_WORKERS + 1);
    localparam int CW  = (MAX_DB_CHUNKS > 1) ? $clog2(MAX_DB_CHUNKS) : 1;
    localparam int WIW = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
    localparam int IW  = (WCW > DW) ? WCW : DW;
    localparam int TW  = $clog2(MAX_QUERY_CHUNKS * MAX_DB_CHUNKS + 1);

    // Configuration registers
    logic [QW-1:0]  r_qcc;
    logic [DW-1:0]  r_dbc;
    logic [WCW-1:0] r_wc;

    // State
    logic [QW-1:0]  r_rem  [MAX_DB_CHUNKS];
    logic [CW-1:0]  r_map  [MAX_WORKERS];
    logic [WCW-1:0] r_load [MAX_DB_CHUNKS];
    logic [TW-1:0]  r_popped;

    // Sequencer
    t_state         r_state;
    t_state         n_state;
    logic [IW-1:0]  r_idx;
    logic [FUNC_W-1:0]   r_func;
    logic [WORKER_W-1:0] r_worker;
    logic [CHUNK_W-1:0]  r_chunk;
    logic [QW-1:0]  r_best_rem;
    logic [WCW-1:0] r_best_ld;
    logic [CW-1:0]  r_target;
    logic           r_tv;
    logic [QC_W-1:0]    r_qc;
    logic [CHUNK_W-1:0] r_dc;

    logic [CFG_QCC_W-1:0] cfg_qcc_v;
    logic [CFG_DBC_W-1:0] cfg_dbc_v;
    logic [CFG_WC_W-1:0]  cfg_wc_v;
    logic [QW-1:0]  cfg_qcc_sat;
    logic [DW-1:0]  cfg_dbc_sat;
    logic [WCW-1:0] cfg_wc_sat;
    logic           cfg_hit;
    logic [QW-1:0]  fill_val;

    logic           in_acc;
    logic           out_free;
    logic [CW-1:0]  rd_addr;
    logic [QW-1:0]  rd_rem;
    logic [WCW-1:0] scan_ld;
    logic [CW-1:0]  map_rd;
    logic           chunk_ok;
    logic           pop_en;
    logic           set_en;
    logic           idx_lt_wc;
    logic           idx_lt_dbc;
    logic           map_in_use;
    logic           ratio_gt;
    logic [QW-1:0]  qc_diff;
    logic [QW+DW-1:0] full_total;
    logic [TW-1:0]  cur_total;

    // Decode and saturate configuration writes
    always_comb begin
        cfg_qcc_v   = i_cfg_data[CFG_QCC_W-1:0];
        cfg_dbc_v   = i_cfg_data[CFG_DBC_W-1:0];
        cfg_wc_v    = i_cfg_data[CFG_WC_W-1:0];
        cfg_qcc_sat = (32'(cfg_qcc_v) > 32'(MAX_QUERY_CHUNKS)) ?
                      QW'(MAX_QUERY_CHUNKS) : QW'(cfg_qcc_v);
        cfg_dbc_sat = (32'(cfg_dbc_v) > 32'(MAX_DB_CHUNKS)) ?
                      DW'(MAX_DB_CHUNKS) : DW'(cfg_dbc_v);
        cfg_wc_sat  = (32'(cfg_wc_v) > 32'(MAX_WORKERS)) ?
                      WCW'(MAX_WORKERS) : WCW'(cfg_wc_v);
        cfg_hit     = i_cfg_we && (i_cfg_addr == CFG_QUERY_CHUNKS ||
                      i_cfg_addr == CFG_DB_CHUNKS || i_cfg_addr == CFG_WORKERS);
        fill_val    = (i_cfg_addr == CFG_QUERY_CHUNKS) ? cfg_qcc_sat : r_qcc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qcc <= QW'(1);
            r_dbc <= DW'(1);
            r_wc  <= WCW'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_QUERY_CHUNKS: r_qcc <= cfg_qcc_sat;
                CFG_DB_CHUNKS:    r_dbc <= cfg_dbc_sat;
                CFG_WORKERS:      r_wc  <= cfg_wc_sat;
                default: ;
            endcase
        end
    end

    // Datapath decode
    always_comb begin
        in_acc     = i_valid && !o_stall;
        out_free   = !o_valid || !i_stall;
        rd_addr    = (r_state == ST_SCAN) ? r_idx[CW-1:0] : CW'(r_chunk);
        rd_rem     = r_rem[rd_addr];
        scan_ld    = r_load[r_idx[CW-1:0]];
        map_rd     = r_map[r_idx[WIW-1:0]];
        chunk_ok   = 32'(r_chunk) < 32'(r_dbc);
        pop_en     = (r_state == ST_EXEC) && (r_func == FUNC_TAKE) && chunk_ok &&
                     (rd_rem != '0);
        set_en     = (r_state == ST_EXEC) && (r_func == FUNC_SET_MAP) && chunk_ok &&
                     (32'(r_worker) < 32'(r_wc));
        idx_lt_wc  = 32'(r_idx) < 32'(r_wc);
        idx_lt_dbc = 32'(r_idx) < 32'(r_dbc);
        map_in_use = 32'(map_rd) < 32'(r_dbc);
        qc_diff    = r_qcc - rd_rem;
        full_total = (QW+DW)'(r_qcc) * (QW+DW)'(r_dbc);
        cur_total  = TW'(full_total) - r_popped;
    end

    // Shared cross-product compare for the ratio search
    ctb_ratio_cmp #(
        .REM_W (QW),
        .LD_W  (WCW)
    ) u_cmp (
        .i_rem       (rd_rem),
        .i_load      (scan_ld),
        .i_best_rem  (r_best_rem),
        .i_best_load (r_best_ld),
        .o_greater   (ratio_gt)
    );

    // Refill chunk counters on reset or any mapped-register write; drop one on a take
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_DB_CHUNKS; i++) r_rem[i] <= QW'(1);
            r_popped <= '0;
        end else if (cfg_hit) begin
            for (int i = 0; i < MAX_DB_CHUNKS; i++) r_rem[i] <= fill_val;
            r_popped <= '0;
        end else if (pop_en) begin
            r_rem[rd_addr] <= rd_rem - QW'(1);
            r_popped       <= r_popped + TW'(1);
        end
    end

    // Loading map
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_WORKERS; i++) r_map[i] <= '0;
        end else if (set_en) begin
            r_map[WIW'(r_worker)] <= CW'(r_chunk);
        end
    end

    // Per-chunk load counters: clear on accept, count during the map walk
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            for (int i = 0; i < MAX_DB_CHUNKS; i++) r_load[i] <= '0;
        end else if (r_state == ST_LOAD && idx_lt_wc && map_in_use) begin
            r_load[map_rd] <= r_load[map_rd] + WCW'(1);
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (in_acc) n_state = ST_EXEC;
            ST_EXEC: n_state = (r_func == FUNC_PICK) ? ST_LOAD : ST_FIN;
            ST_LOAD: if (!idx_lt_wc) n_state = ST_SCAN;
            ST_SCAN: begin
                if (!idx_lt_dbc || (scan_ld == '0 && rd_rem != '0)) n_state = ST_FIN;
            end
            ST_FIN:  if (out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    // Capture the item and run the sequencer datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    r_func     <= i_func;
                    r_worker   <= i_worker;
                    r_chunk    <= i_chunk;
                    r_tv       <= 1'b0;
                    r_qc       <= '0;
                    r_dc       <= '0;
                    r_target   <= '0;
                    r_best_rem <= '0;
                    r_best_ld  <= WCW'(1);
                end
            end
            ST_EXEC: begin
                r_idx <= '0;
                if (pop_en) begin
                    r_tv <= 1'b1;
                    r_qc <= QC_W'(qc_diff);
                    r_dc <= r_chunk;
                end
            end
            ST_LOAD: begin
                if (idx_lt_wc) r_idx <= r_idx + IW'(1);
                else           r_idx <= '0;
            end
            ST_SCAN: begin
                if (idx_lt_dbc) begin
                    r_idx <= r_idx + IW'(1);
                    if (scan_ld == '0) begin
                        if (rd_rem != '0) r_target <= r_idx[CW-1:0];
                    end else if (ratio_gt) begin
                        r_best_rem <= rd_rem;
                        r_best_ld  <= scan_ld;
                        r_target   <= r_idx[CW-1:0];
                    end
                end
            end
            default: ;
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (r_state == ST_FIN && out_free) begin
            o_valid <= 1'b1;
        end else if (!i_stall) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_FIN && out_free) begin
            o_task_valid      <= r_tv;
            o_query_idx       <= r_qc;
            o_db_chunk        <= r_dc;
            o_switch_chunk    <= TGT_W'(r_target);
            o_remaining_total <= RT_W'(cur_total);
        end
    end

    // Hold off new items while one is in flight
    assign o_stall = (r_state != ST_IDLE);

endmodule

`default_nettype wire

FILE: sv/ctb_checker.sv
`default_nettype none
`include "chunk_task_balancer_core_defines.svh"

module ctb_checker
    import ctb_pkg::*;
(
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_valid,
    input wire logic                o_stall,
    input wire logic                o_valid,
    input wire logic                i_stall,
    input wire logic                o_task_valid,
    input wire logic [QC_W-1:0]     o_query_idx,
    input wire logic [CHUNK_W-1:0]  o_db_chunk,
    input wire logic [TGT_W-1:0]    o_switch_chunk,
    input wire logic [RT_W-1:0]     o_remaining_total
);

    // A stalled result stays offered and unchanged
    `CTB_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid)
    `CTB_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_valid && i_stall,
                     $stable(o_remaining_total) && $stable(o_switch_chunk) &&
                     $stable(o_query_idx))

    // One item at a time: an accepted item blocks the input next cycle
    `CTB_ASSERT_NEXT(a_busy_after_acc, i_clk, i_rst_n, i_valid && !o_stall, o_stall)

    // No task taken means the task fields read zero
    `CTB_ASSERT_NOW(a_no_task_zero, i_clk, i_rst_n, o_valid && !o_task_valid,
                    o_query_idx == '0 && o_db_chunk == '0)

    // A take never reports a switch target
    `CTB_ASSERT_NOW(a_task_no_target, i_clk, i_rst_n, o_valid && o_task_valid,
                    o_switch_chunk == '0)

endmodule

bind chunk_task_balancer_core ctb_checker u_ctb_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_valid           (i_valid),
    .o_stall           (o_stall),
    .o_valid           (o_valid),
    .i_stall           (i_stall),
    .o_task_valid      (o_task_valid),
    .o_query_idx       (o_query_idx),
    .o_db_chunk        (o_db_chunk),
    .o_switch_chunk    (o_switch_chunk),
    .o_remaining_total (o_remaining_total)
);

`default_nettype wire

FILE: sim/ctb_result_checker.sv
`timescale 1ns / 100ps

module ctb_result_checker
    import ctb_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // configuration writes
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_AW-1:0]    i_cfg_addr,
    input  wire logic [CFG_DW-1:0]    i_cfg_data,
    // request channel
    input  wire logic                 i_req_valid,
    input  wire logic                 i_req_stall,
    input  wire logic [FUNC_W-1:0]    i_func,
    input  wire logic [WORKER_W-1:0]  i_worker,
    input  wire logic [CHUNK_W-1:0]   i_chunk,
    // result channel
    input  wire logic                 i_res_valid,
    input  wire logic                 i_res_stall,
    input  wire logic                 i_task_valid,
    input  wire logic [QC_W-1:0]      i_query_idx,
    input  wire logic [CHUNK_W-1:0]   i_db_chunk,
    input  wire logic [TGT_W-1:0]     i_switch_chunk,
    input  wire logic [RT_W-1:0]      i_remaining_total,
    // status for the top
    output int                        o_fail_count,
    output int                        o_pending
);

    localparam int LIMIT_CHUNKS  = 16;
    localparam int LIMIT_WORKERS = 32;
    localparam int LIMIT_QUERY   = 1024;

    typedef struct packed {
        logic               task_valid;
        logic [QC_W-1:0]    query_idx;
        logic [CHUNK_W-1:0] db_chunk;
        logic [TGT_W-1:0]   switch_chunk;
        logic [RT_W-1:0]    remaining_total;
    } t_result;

    // Dispatcher state as the block should hold it
    logic [CFG_QCC_W-1:0] tasks_per_chunk;
    logic [CFG_DBC_W-1:0] chunks_used;
    logic [CFG_WC_W-1:0]  workers_used;
    logic [CFG_QCC_W-1:0] tasks_left [LIMIT_CHUNKS];
    logic [CHUNK_W-1:0]   loaded_chunk [LIMIT_WORKERS];

    t_result expected_q [$];
    int      mismatches = 0;

    task automatic refill_counters();
        foreach (tasks_left[i]) tasks_left[i] = tasks_per_chunk;
    endtask

    function automatic logic [RT_W-1:0] tasks_total();
        logic [RT_W-1:0] sum;
        sum = '0;
        for (int i = 0; i < LIMIT_CHUNKS; i++) begin
            if (i < chunks_used)
                sum += RT_W'(tasks_left[i]);
        end
        return sum;
    endfunction

    // First idle chunk with work, else best remaining/loads ratio by cross product
    function automatic logic [TGT_W-1:0] choose_switch_chunk();
        int                loads [LIMIT_CHUNKS];
        longint unsigned   best_rem;
        longint unsigned   best_load;
        longint unsigned   rem;
        longint unsigned   load_here;
        logic [TGT_W-1:0]  pick;
        best_rem  = 0;
        best_load = 1;
        pick      = '0;
        foreach (loads[i]) loads[i] = 0;
        for (int i = 0; i < LIMIT_WORKERS; i++) begin
            if (i < workers_used && loaded_chunk[i] < chunks_used)
                loads[loaded_chunk[i]]++;
        end
        for (int i = 0; i < LIMIT_CHUNKS; i++) begin
            if (i >= chunks_used)
                break;
            rem       = tasks_left[i];
            load_here = loads[i];
            if (load_here == 0) begin
                if (rem != 0)
                    return TGT_W'(i);
                continue;
            end
            if (rem * best_load > best_rem * load_here) begin
                best_rem  = rem;
                best_load = load_here;
                pick      = TGT_W'(i);
            end
        end
        return pick;
    endfunction

    task automatic apply_write(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] data);
        case (addr)
            CFG_QUERY_CHUNKS: begin
                tasks_per_chunk = (data > LIMIT_QUERY) ? CFG_QCC_W'(LIMIT_QUERY) : data;
            end
            CFG_DB_CHUNKS: begin
                chunks_used = (data[CFG_DBC_W-1:0] > LIMIT_CHUNKS) ?
                              CFG_DBC_W'(LIMIT_CHUNKS) : data[CFG_DBC_W-1:0];
            end
            CFG_WORKERS: begin
                workers_used = (data[CFG_WC_W-1:0] > LIMIT_WORKERS) ?
                               CFG_WC_W'(LIMIT_WORKERS) : data[CFG_WC_W-1:0];
            end
            default: return;
        endcase
        refill_counters();
    endtask

    // Advance the state by one request and return the result it gives
    function automatic t_result predict_item(input logic [FUNC_W-1:0]   req_func,
                                             input logic [WORKER_W-1:0] req_worker,
                                             input logic [CHUNK_W-1:0]  req_chunk);
        t_result              res;
        logic [CFG_QCC_W-1:0] issued;
        res = '0;
        case (req_func)
            FUNC_SET_MAP: begin
                if (req_worker < workers_used && req_chunk < chunks_used)
                    loaded_chunk[req_worker] = req_chunk;
            end
            FUNC_TAKE: begin
                if (req_chunk < chunks_used && tasks_left[req_chunk] != 0) begin
                    issued               = tasks_per_chunk - tasks_left[req_chunk];
                    res.task_valid       = 1'b1;
                    res.query_idx        = issued[QC_W-1:0];
                    res.db_chunk         = req_chunk;
                    tasks_left[req_chunk] = tasks_left[req_chunk] - 1'b1;
                end
            end
            FUNC_PICK: begin
                res.switch_chunk = choose_switch_chunk();
            end
            default: ;
        endcase
        res.remaining_total = tasks_total();
        return res;
    endfunction

    task automatic check_field(input string label, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s expected %0d, actual %0d", $time, label, want, got);
            mismatches++;
        end
    endtask

    // Watch both channels and the register port on every edge
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            tasks_per_chunk = 1;
            chunks_used     = 1;
            workers_used    = 1;
            refill_counters();
            foreach (loaded_chunk[i]) loaded_chunk[i] = '0;
            expected_q.delete();
        end else begin
            if (i_res_valid && !i_res_stall) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: result item with no request outstanding", $time);
                    mismatches++;
                end else begin
                    want = expected_q.pop_front();
                    check_field("task_valid", want.task_valid, i_task_valid);
                    check_field("query_idx", want.query_idx, i_query_idx);
                    check_field("db_chunk", want.db_chunk, i_db_chunk);
                    check_field("switch_chunk", want.switch_chunk, i_switch_chunk);
                    check_field("remaining_total", want.remaining_total, i_remaining_total);
                end
            end
            if (i_cfg_we)
                apply_write(i_cfg_addr, i_cfg_data);
            if (i_req_valid && !i_req_stall)
                expected_q.push_back(predict_item(i_func, i_worker, i_chunk));
        end
        o_pending    <= expected_q.size();
        o_fail_count <= mismatches;
    end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import ctb_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_UNDEF = 2'd3;
    localparam logic [CFG_AW-1:0] CFG_SPARE  = 2'd3;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [CFG_AW-1:0]   i_cfg_addr;
    logic [CFG_DW-1:0]   i_cfg_data;
    logic                i_valid;
    logic                o_stall;
    logic [FUNC_W-1:0]   i_func;
    logic [WORKER_W-1:0] i_worker;
    logic [CHUNK_W-1:0]  i_chunk;
    logic                o_valid;
    logic                i_stall;
    logic                o_task_valid;
    logic [QC_W-1:0]     o_query_idx;
    logic [CHUNK_W-1:0]  o_db_chunk;
    logic [TGT_W-1:0]    o_switch_chunk;
    logic [RT_W-1:0]     o_remaining_total;

    int fail_count;
    int pending;

    // Stimulus knobs, some shared with the receiver process
    bit idle_on  = 1'b1;
    bit hold_req = 1'b0;
    int cur_dbc  = 1;
    int cur_wc   = 1;
    int items_sent    = 0;
    int settings_used = 0;

    chunk_task_balancer_core u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_addr        (i_cfg_addr),
        .i_cfg_data        (i_cfg_data),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_func            (i_func),
        .i_worker          (i_worker),
        .i_chunk           (i_chunk),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_task_valid      (o_task_valid),
        .o_query_idx       (o_query_idx),
        .o_db_chunk        (o_db_chunk),
        .o_switch_chunk    (o_switch_chunk),
        .o_remaining_total (o_remaining_total)
    );

    ctb_result_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_addr        (i_cfg_addr),
        .i_cfg_data        (i_cfg_data),
        .i_req_valid       (i_valid),
        .i_req_stall       (o_stall),
        .i_func            (i_func),
        .i_worker          (i_worker),
        .i_chunk           (i_chunk),
        .i_res_valid       (o_valid),
        .i_res_stall       (i_stall),
        .i_task_valid      (o_task_valid),
        .i_query_idx       (o_query_idx),
        .i_db_chunk        (o_db_chunk),
        .i_switch_chunk    (o_switch_chunk),
        .i_remaining_total (o_remaining_total),
        .o_fail_count      (fail_count),
        .o_pending         (pending)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Offer one item, with an occasional gap first, and hold it until taken
    task automatic send_item(input logic [FUNC_W-1:0]   f,
                             input logic [WORKER_W-1:0] w,
                             input logic [CHUNK_W-1:0]  c);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_func   <= f;
        i_worker <= w;
        i_chunk  <= c;
        do @(posedge i_clk); while (o_stall);
        items_sent++;
    endtask

    // Stop offering and wait for every outstanding result
    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic setup(input logic [CFG_DW-1:0] qcc,
                         input logic [CFG_DW-1:0] dbc,
                         input logic [CFG_DW-1:0] wc);
        write_reg(CFG_QUERY_CHUNKS, qcc);
        write_reg(CFG_DB_CHUNKS, dbc);
        write_reg(CFG_WORKERS, wc);
        cur_dbc = (dbc[CFG_DBC_W-1:0] > 16) ? 16 : dbc[CFG_DBC_W-1:0];
        cur_wc  = (wc[CFG_WC_W-1:0] > 32) ? 32 : wc[CFG_WC_W-1:0];
        settings_used++;
    endtask

    // Mostly in-range workers and chunks, with some out-of-range noise
    task automatic random_phase(input int count, input bit take_heavy);
        int                  r;
        logic [FUNC_W-1:0]   f;
        logic [WORKER_W-1:0] w;
        logic [CHUNK_W-1:0]  c;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (take_heavy && r < 80)
                f = FUNC_TAKE;
            else if (r < 30)
                f = FUNC_SET_MAP;
            else if (r < 68)
                f = FUNC_TAKE;
            else if (r < 94)
                f = FUNC_PICK;
            else
                f = FUNC_UNDEF;
            if (cur_wc == 0 || $urandom_range(0, 9) == 0)
                w = WORKER_W'($urandom_range(0, 31));
            else
                w = WORKER_W'($urandom_range(0, cur_wc - 1));
            if (cur_dbc == 0 || $urandom_range(0, 9) == 0)
                c = CHUNK_W'($urandom_range(0, 15));
            else
                c = CHUNK_W'($urandom_range(0, cur_dbc - 1));
            send_item(f, w, c);
        end
    endtask

    // Receiver: random stall bursts, plus one long hold-off on request
    initial begin
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_stall <= 1'b1;
                repeat (300) @(posedge i_clk);
                i_stall <= 1'b0;
                hold_req = 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    initial begin
        int guard;
        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_addr <= CFG_QUERY_CHUNKS;
        i_cfg_data <= '0;
        i_valid    <= 1'b0;
        i_func     <= FUNC_SET_MAP;
        i_worker   <= '0;
        i_chunk    <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset state: one task in chunk 0, worker 0 on chunk 0
        send_item(FUNC_TAKE, 5'd0, 4'd0);
        send_item(FUNC_PICK, 5'd0, 4'd0);
        send_item(FUNC_TAKE, 5'd0, 4'd0);
        drain();
        // Unmapped register index must not refill
        write_reg(CFG_SPARE, 11'h7FF);
        send_item(FUNC_TAKE, 5'd0, 4'd0);
        drain();

        // Small setup: idle chunk first, then ratio ties and out-of-range requests
        setup(11'd3, 11'd4, 11'd5);
        send_item(FUNC_PICK, 5'd0, 4'd0);
        send_item(FUNC_SET_MAP, 5'd1, 4'd1);
        send_item(FUNC_SET_MAP, 5'd2, 4'd2);
        send_item(FUNC_SET_MAP, 5'd3, 4'd3);
        send_item(FUNC_TAKE, 5'd0, 4'd3);
        send_item(FUNC_TAKE, 5'd0, 4'd3);
        send_item(FUNC_SET_MAP, 5'd4, 4'd3);
        send_item(FUNC_PICK, 5'd0, 4'd0);
        send_item(FUNC_TAKE, 5'd0, 4'd0);
        send_item(FUNC_PICK, 5'd0, 4'd0);
        send_item(FUNC_SET_MAP, 5'd31, 4'd0);
        send_item(FUNC_SET_MAP, 5'd0, 4'd15);
        send_item(FUNC_TAKE, 5'd0, 4'd15);
        send_item(FUNC_UNDEF, 5'd31, 4'd15);
        send_item(FUNC_TAKE, 5'd0, 4'd3);
        send_item(FUNC_TAKE, 5'd0, 4'd3);
        send_item(FUNC_PICK, 5'd0, 4'd0);
        drain();

        // No chunks in use: nothing to count, take or pick
        write_reg(CFG_DB_CHUNKS, 11'd0);
        cur_dbc = 0;
        send_item(FUNC_PICK, 5'd0, 4'd0);
        send_item(FUNC_TAKE, 5'd0, 4'd0);
        send_item(FUNC_SET_MAP, 5'd0, 4'd0);

        for (int p = 0; p < 9; p++) begin
            drain();
            case (p)
                0: setup(11'h7FF, 11'd31, 11'd63);
                1: setup(11'd0, 11'd16, 11'd32);
                2: setup(11'd1, 11'd1, 11'd1);
                3: setup(CFG_DW'($urandom_range(1, 6)), CFG_DW'($urandom_range(1, 16)),
                         11'd0);
                4: setup(11'd1024, 11'd1, 11'd3);
                default: begin
                    if ($urandom_range(0, 3) == 0)
                        setup(CFG_DW'($urandom_range(0, 2047)),
                              CFG_DW'($urandom_range(0, 2047)),
                              CFG_DW'($urandom_range(0, 2047)));
                    else
                        setup(CFG_DW'($urandom_range(1, 6)),
                              CFG_DW'($urandom_range(1, 16)),
                              CFG_DW'($urandom_range(1, 32)));
                end
            endcase
            idle_on = (p == 8) ? 1'b0 : ($urandom_range(0, 3) != 0);
            if (p == 2)
                hold_req = 1'b1;
            random_phase((p == 4) ? 90 : 40, p == 4);
        end

        // Let the last results come out, within a bound
        i_valid <= 1'b0;
        guard = 0;
        do begin
            @(posedge i_clk);
            guard++;
        end while (pending != 0 && guard < 20000);
        repeat (60) @(posedge i_clk);

        $display("Run covered %0d request items over %0d register setups,", items_sent,
                 settings_used);
        $display("including saturated, zero and single-chunk setups and a long receiver hold.");
        if (fail_count == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Give up if the run hangs
    initial begin
        #5000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: files.f
+incdir+sv
sv/ctb_pkg.sv
sv/ctb_ratio_cmp.sv
sv/chunk_task_balancer_core.sv
sv/ctb_checker.sv
sim/ctb_result_checker.sv
sim/testbench.sv
